// ===== design/gfw_pkg.sv =====
// Shared types, opcodes and the 5x7 font table for the glyph framebuffer writer.
// Used by gfw_merge and glyph_framebuffer_writer_core; depends on nothing.
`default_nettype none

package gfw_pkg;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_PIXEL = 2'd1,
      OP_CHAR  = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   localparam logic [7:0] FIRST_CODE    = 8'd32;
   localparam logic [7:0] LAST_CODE     = 8'd90;
   localparam logic [7:0] FALLBACK_CODE = 8'd63;
   localparam int         GLYPH_COLS    = 5;
   localparam int         GLYPH_ROWS    = 7;
   localparam int         FONT_BYTES    = (90 - 32 + 1) * GLYPH_COLS;

   localparam logic [7:0] FONT_ROM [0:FONT_BYTES-1] = '{
      8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5F,8'h00,8'h00,
      8'h00,8'h07,8'h00,8'h07,8'h00, 8'h14,8'h7F,8'h14,8'h7F,8'h14,
      8'h24,8'h2A,8'h7F,8'h2A,8'h12, 8'h23,8'h13,8'h08,8'h64,8'h62,
      8'h36,8'h49,8'h56,8'h20,8'h50, 8'h00,8'h08,8'h07,8'h03,8'h00,
      8'h00,8'h1C,8'h22,8'h41,8'h00, 8'h00,8'h41,8'h22,8'h1C,8'h00,
      8'h2A,8'h1C,8'h7F,8'h1C,8'h2A, 8'h08,8'h08,8'h3E,8'h08,8'h08,
      8'h00,8'h80,8'h70,8'h30,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08,
      8'h00,8'h00,8'h60,8'h60,8'h00, 8'h20,8'h10,8'h08,8'h04,8'h02,
      8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h42,8'h7F,8'h40,8'h00,
      8'h72,8'h49,8'h49,8'h49,8'h46, 8'h21,8'h41,8'h49,8'h4D,8'h33,
      8'h18,8'h14,8'h12,8'h7F,8'h10, 8'h27,8'h45,8'h45,8'h45,8'h39,
      8'h3C,8'h4A,8'h49,8'h49,8'h31, 8'h41,8'h21,8'h11,8'h09,8'h07,
      8'h36,8'h49,8'h49,8'h49,8'h36, 8'h46,8'h49,8'h49,8'h29,8'h1E,
      8'h00,8'h00,8'h14,8'h00,8'h00, 8'h00,8'h40,8'h34,8'h00,8'h00,
      8'h00,8'h08,8'h14,8'h22,8'h41, 8'h14,8'h14,8'h14,8'h14,8'h14,
      8'h00,8'h41,8'h22,8'h14,8'h08, 8'h02,8'h01,8'h59,8'h09,8'h06,
      8'h3E,8'h41,8'h5D,8'h59,8'h4E, 8'h7C,8'h12,8'h11,8'h12,8'h7C,
      8'h7F,8'h49,8'h49,8'h49,8'h36, 8'h3E,8'h41,8'h41,8'h41,8'h22,
      8'h7F,8'h41,8'h41,8'h41,8'h3E, 8'h7F,8'h49,8'h49,8'h49,8'h41,
      8'h7F,8'h09,8'h09,8'h09,8'h01, 8'h3E,8'h41,8'h41,8'h51,8'h73,
      8'h7F,8'h08,8'h08,8'h08,8'h7F, 8'h00,8'h41,8'h7F,8'h41,8'h00,
      8'h20,8'h40,8'h41,8'h3F,8'h01, 8'h7F,8'h08,8'h14,8'h22,8'h41,
      8'h7F,8'h40,8'h40,8'h40,8'h40, 8'h7F,8'h02,8'h1C,8'h02,8'h7F,
      8'h7F,8'h04,8'h08,8'h10,8'h7F, 8'h3E,8'h41,8'h41,8'h41,8'h3E,
      8'h7F,8'h09,8'h09,8'h09,8'h06, 8'h3E,8'h41,8'h51,8'h21,8'h5E,
      8'h7F,8'h09,8'h19,8'h29,8'h46, 8'h26,8'h49,8'h49,8'h49,8'h32,
      8'h03,8'h01,8'h7F,8'h01,8'h03, 8'h3F,8'h40,8'h40,8'h40,8'h3F,
      8'h1F,8'h20,8'h40,8'h20,8'h1F, 8'h3F,8'h40,8'h38,8'h40,8'h3F,
      8'h63,8'h14,8'h08,8'h14,8'h63, 8'h03,8'h04,8'h78,8'h04,8'h03,
      8'h61,8'h59,8'h49,8'h4D,8'h43
   };

   // One column of a glyph; codes without a glyph map to the question mark.
   function automatic logic [7:0] font_column(input logic [7:0] code, input logic [2:0] col);
      logic [7:0] eff;
      logic [5:0] sel;
      logic [8:0] idx;
      eff = ((code < FIRST_CODE) || (code > LAST_CODE)) ? FALLBACK_CODE : code;
      sel = 6'(eff - FIRST_CODE);
      idx = 9'(9'(sel) * 9'(GLYPH_COLS)) + 9'(col);
      return FONT_ROM[idx];
   endfunction

   // Request into the read-modify-write merge unit.
   typedef struct packed {
      logic [7:0] old_byte;
      logic [6:0] col_bits;
      logic [6:0] row_enable;
      logic [2:0] shift;
      logic       upper_half;
      logic [7:0] row_limit;
   } merge_req_type;

   typedef struct packed {
      logic [7:0] new_byte;
      logic [7:0] mask;
   } merge_rsp_type;

endpackage

`default_nettype wire

// ===== design/gfw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`default_nettype none

module gfw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== design/gfw_merge.sv =====
// Shared read-modify-write unit: aligns a glyph or pixel column to a page byte
// and merges it into the old store byte. Depends on gfw_pkg.
`default_nettype none

module gfw_merge (
   input  wire gfw_pkg::merge_req_type req,
   output gfw_pkg::merge_rsp_type      rsp
);

   logic [14:0] val_wide;
   logic [14:0] mask_wide;
   logic [7:0]  val_byte;
   logic [7:0]  mask_byte;

   always_comb begin
      val_wide  = 15'(req.col_bits & req.row_enable) << req.shift;
      mask_wide = 15'(req.row_enable) << req.shift;
      // The upper half is the page below, which gets the rows shifted out.
      if (req.upper_half) begin
         val_byte  = {1'b0, val_wide[14:8]};
         mask_byte = {1'b0, mask_wide[14:8]};
      end else begin
         val_byte  = val_wide[7:0];
         mask_byte = mask_wide[7:0];
      end
      mask_byte    = mask_byte & req.row_limit;
      rsp.mask     = mask_byte;
      rsp.new_byte = (req.old_byte & ~mask_byte) | (val_byte & mask_byte);
   end

endmodule

`default_nettype wire

// ===== design/glyph_framebuffer_writer_core.sv =====
// Top level of the glyph framebuffer writer: sequencer, store and response register.
// Depends on gfw_pkg, gfw_ram and gfw_merge.
//
//   Channel | Direction | Handshake              | Contents
//   req_    | in        | req_tvalid/req_tready  | one request: opcode and operands
//   rsp_    | out       | rsp_tvalid/rsp_tready  | one response per request
//
// After reset the store is swept to zero, one byte per cycle: SCREEN_WIDTH times
// the page count bytes (1024 at the defaults), with req_tready low meanwhile.
// A clear request takes the same sweep. A pixel write is a read-modify-write of
// one byte and responds as that byte is written; a character walks five
// columns times two pages through the one merge unit, the read of one step
// overlapping the write of the one before, and responds as the last step is written.
// A read responds from the read state with the byte it fetched from the store.
// One request is in work at a time; the next is taken once the response is taken.
`default_nettype none

module glyph_framebuffer_writer_core #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // pos_x[8:0], pos_y[17:9], pixel_on[18], char_code[26:19], byte_index[36:27]
   input  wire logic [39:0] req_tdata,
   // opcode[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // read_data[7:0], op_done[8]
   output logic [15:0]      rsp_tdata
);

   localparam int PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;
   localparam int STORE_SIZE = SCREEN_WIDTH * PAGE_COUNT;
   localparam int AW         = $clog2(STORE_SIZE);
   localparam logic [7:0] LAST_ROWS =
      (SCREEN_HEIGHT % 8 == 0) ? 8'hFF : 8'((1 << (SCREEN_HEIGHT % 8)) - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_DRAW
   } state_type;

   state_type      state_ff;
   logic [AW-1:0]  clr_cnt_ff;
   logic           clr_resp_ff;
   logic           rsp_tvalid_ff;
   logic [15:0]    rsp_tdata_ff;
   gfw_pkg::op_type op_ff;
   logic [8:0]     x_ff;
   logic [8:0]     y_ff;
   logic           on_ff;
   logic [7:0]     code_ff;
   logic           rd_ok_ff;
   logic [3:0]     cnt_ff;
   logic [3:0]     nsteps_ff;
   logic           pipe_ff;
   logic [AW-1:0]  wr_addr_ff;
   logic           wr_ok_ff;
   logic [2:0]     wr_col_ff;
   logic           wr_half_ff;
   logic           wr_last_ff;

   logic           accept;
   gfw_pkg::op_type req_op;
   logic [2:0]     step_col;
   logic           step_half;
   logic [9:0]     col_pos;
   logic [6:0]     page_pos;
   logic           step_ok;
   logic [AW-1:0]  step_addr;
   logic [7:0]     glyph_bits;

   logic           ram_we;
   logic [AW-1:0]  ram_waddr;
   logic [7:0]     ram_wdata;
   logic [AW-1:0]  ram_raddr;
   logic [7:0]     ram_rdata;

   gfw_pkg::merge_req_type mreq;
   gfw_pkg::merge_rsp_type mrsp;

   assign req_tready = (state_ff == ST_IDLE) && !rsp_tvalid_ff;
   assign accept     = req_tvalid && req_tready;
   assign req_op     = gfw_pkg::op_type'(req_tuser);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Step address: a character runs column by column, top page then the page below.
   always_comb begin
      if (op_ff == gfw_pkg::OP_CHAR) begin
         step_col  = cnt_ff[3:1];
         step_half = cnt_ff[0];
      end else begin
         step_col  = 3'd0;
         step_half = 1'b0;
      end
      col_pos   = {x_ff[8], x_ff} + {7'd0, step_col};
      page_pos  = {y_ff[8], y_ff[8:3]} + {6'd0, step_half};
      step_ok   = !col_pos[9] && (col_pos < 10'(SCREEN_WIDTH))
                  && !page_pos[6] && (page_pos < 7'(PAGE_COUNT));
      step_addr = AW'(col_pos) + AW'(AW'(page_pos) * AW'(SCREEN_WIDTH));
   end

   assign glyph_bits = gfw_pkg::font_column(code_ff, wr_col_ff);

   always_comb begin
      mreq.old_byte = ram_rdata;
      if (op_ff == gfw_pkg::OP_CHAR) begin
         mreq.col_bits   = glyph_bits[6:0];
         mreq.row_enable = 7'h7F;
      end else begin
         mreq.col_bits   = {7{on_ff}};
         mreq.row_enable = 7'h01;
      end
      mreq.shift      = y_ff[2:0];
      mreq.upper_half = wr_half_ff;
      mreq.row_limit  = wr_last_ff ? LAST_ROWS : 8'hFF;
   end

   gfw_merge u_merge (
      .req (mreq),
      .rsp (mrsp)
   );

   // Store port steering: the clearing sweep owns the write port while it runs.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = wr_addr_ff;
      ram_wdata = mrsp.new_byte;
      ram_raddr = step_addr;
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_cnt_ff;
         ram_wdata = 8'd0;
      end else if (state_ff == ST_DRAW) begin
         ram_we = pipe_ff && wr_ok_ff && (mrsp.mask != 8'd0);
      end
      if (state_ff == ST_IDLE) begin
         ram_raddr = AW'(req_tdata[36:27]);
      end
   end

   gfw_ram #(
      .WIDTH (8),
      .DEPTH (STORE_SIZE)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         clr_resp_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         pipe_ff       <= 1'b0;
         cnt_ff        <= 4'd0;
         nsteps_ff     <= 4'd0;
         op_ff         <= gfw_pkg::OP_CLEAR;
      end else begin
         if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == AW'(STORE_SIZE - 1)) begin
                  clr_cnt_ff  <= '0;
                  clr_resp_ff <= 1'b0;
                  state_ff    <= ST_IDLE;
                  if (clr_resp_ff) begin
                     rsp_tvalid_ff <= 1'b1;
                     rsp_tdata_ff  <= 16'h0100;
                  end
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  op_ff    <= req_op;
                  x_ff     <= req_tdata[8:0];
                  y_ff     <= req_tdata[17:9];
                  on_ff    <= req_tdata[18];
                  code_ff  <= req_tdata[26:19];
                  rd_ok_ff <= 32'(req_tdata[36:27]) < 32'(STORE_SIZE);
                  cnt_ff   <= 4'd0;
                  pipe_ff  <= 1'b0;
                  unique case (req_op)
                     gfw_pkg::OP_CLEAR: begin
                        clr_resp_ff <= 1'b1;
                        state_ff    <= ST_CLEAR;
                     end
                     gfw_pkg::OP_PIXEL: begin
                        nsteps_ff <= 4'd1;
                        state_ff  <= ST_DRAW;
                     end
                     gfw_pkg::OP_CHAR: begin
                        nsteps_ff <= 4'(2 * gfw_pkg::GLYPH_COLS);
                        state_ff  <= ST_DRAW;
                     end
                     gfw_pkg::OP_READ: begin
                        state_ff <= ST_READ;
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_READ: begin
               rsp_tvalid_ff <= 1'b1;
               rsp_tdata_ff  <= {7'd0, 1'b1, (rd_ok_ff ? ram_rdata : 8'd0)};
               state_ff      <= ST_IDLE;
            end
            ST_DRAW: begin
               // Issue the read of this step; its merge and write follow next cycle.
               if (cnt_ff < nsteps_ff) begin
                  pipe_ff    <= 1'b1;
                  wr_addr_ff <= step_addr;
                  wr_ok_ff   <= step_ok;
                  wr_col_ff  <= step_col;
                  wr_half_ff <= step_half;
                  wr_last_ff <= page_pos == 7'(PAGE_COUNT - 1);
                  cnt_ff     <= cnt_ff + 4'd1;
               end else begin
                  pipe_ff       <= 1'b0;
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= 16'h0100;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // No request may be taken while the store is being swept.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("request accepted during store clear");

   // The store is only written by a clear sweep or a drawing step.
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_READ) |-> !ram_we)
      else $error("store written outside clear or draw");

   // Only a read request returns a nonzero data byte.
   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && op_ff != gfw_pkg::OP_READ) |-> (rsp_tdata_ff[7:0] == 8'd0))
      else $error("nonzero data for a non-read request");

   // The step counter never runs past the step count of the request.
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAW) |-> (cnt_ff <= nsteps_ff))
      else $error("drawing step counter overran");

   // A response is raised only as the sequencer returns to idle.
   a_rsp_on_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> (state_ff == ST_IDLE))
      else $error("response raised while work continues");

endmodule

`default_nettype wire
